// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
// Shared package of the first-fit block allocator: sizes, command and status codes,
// the request and result payload types and the free-list store interface types.
// Depends on nothing; every other file of the allocator uses it.
package ffba_pkg;

	// Pool geometry.
	localparam int POOL_DEPTH  = 1024;
	localparam int BLOCK_BYTES = 16;
	localparam int ADDR_W      = $clog2(POOL_DEPTH);
	localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

	// Fixed field widths.
	localparam int POOL_W  = 11;
	localparam int BYTES_W = 16;

	// Largest block count one acquire can ask for, header block included.
	localparam int NEED_MAX = ((1 << BYTES_W) - 1 + BLOCK_BYTES - 1) / BLOCK_BYTES + 1;
	localparam int NEED_W   = $clog2(NEED_MAX + 1);

	// A split can point a link past the pool, so links are wider than addresses.
	localparam int IDX_W = $clog2(POOL_DEPTH + NEED_MAX);
	localparam int LEN_W = 32;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
	localparam logic [1:0] STATUS_RANGE     = 2'd2;

	typedef struct packed {
		logic        command;
		logic [15:0] request_bytes;
		logic [9:0]  release_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] block_index;
	} rsp_t;

	// One free-list header: run length and link to the next free run.
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [IDX_W-1:0] link;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} store_req_t;

endpackage

// ===== rtl/core/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps
// Top level of the first-fit block allocator: command channel, result strobe,
// pool size register and the sequencer that walks and edits the free list.
// Depends on ffba_pkg and ffba_store.
//
// Usage. A command is taken at a rising edge where start is high and busy is low.
// An acquire turns request_bytes into whole blocks plus one header block and takes
// the first free run that is long enough; a release puts a run back into the
// address-ordered free list and merges it with free neighbors that touch it.
// Each command produces exactly one result, shown on result for one cycle while
// done is high. The receiver cannot hold results off, and busy drops in the same
// cycle that done rises, so a new command can follow right away.
// The free list lives in a memory with registered read data, and the walk reads one
// run header per cycle. An acquire reads the list head and then visits free runs until
// one is long enough; a release first walks past the free runs that lie below the
// released index. A release with an index out of range answers in the cycle after it
// is taken. The walk is bounded by the pool size.
// Reset and every transfer on the cfg channel (taken while no command is in flight)
// set the pool size, saturated to 2 .. 1024, and rebuild one free run: a clearing
// pass writes one header per cycle over the configured pool, with busy high.
module first_fit_block_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  ffba_pkg::req_t               request,
	output logic                         done,
	output ffba_pkg::rsp_t               result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ffba_pkg::POOL_W-1:0]  cfg_data
);

	localparam int IDX_W  = ffba_pkg::IDX_W;
	localparam int LEN_W  = ffba_pkg::LEN_W;
	localparam int NEED_W = ffba_pkg::NEED_W;
	localparam int ADDR_W = ffba_pkg::ADDR_W;
	localparam int POOL_W = ffba_pkg::POOL_W;

	// The sequencer issues at most one memory access per cycle. A state that
	// consumes read data always follows the state that issued the read, and
	// every header that is rewritten is read again after the last write, so
	// no access to an entry ever overlaps another one.
	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_AHEAD,
		S_ACUR,
		S_AFOUND,
		S_APRD,
		S_APWR,
		S_ACRD,
		S_ACWR,
		S_RHEAD,
		S_RWALK,
		S_RBLK,
		S_RBLKD,
		S_RNXTD,
		S_RPREV,
		S_RPREVD,
		S_RFIX,
		S_RLINK
	} state_t;

	state_t                 state_q;
	logic [POOL_W-1:0]      pool_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [NEED_W-1:0]      need_q;
	logic [IDX_W-1:0]       blk_q;
	logic [IDX_W-1:0]       prev_q;
	logic [IDX_W-1:0]       cur_q;
	logic [IDX_W-1:0]       link_q;
	logic [POOL_W-1:0]      steps_q;
	ffba_pkg::entry_t       ea_q;
	ffba_pkg::entry_t       eb_q;
	logic                   done_q;
	ffba_pkg::rsp_t         result_q;

	ffba_pkg::store_req_t   mreq;
	ffba_pkg::entry_t       rd_data;
	ffba_pkg::entry_t       clr_data;

	logic                   take;
	logic                   cfg_fire;
	logic [POOL_W-1:0]      cfg_sat;
	logic [POOL_W-1:0]      pool_last;
	logic [POOL_W-1:0]      steps_inc;
	logic [LEN_W-1:0]       need_len;
	logic [IDX_W-1:0]       rest;
	logic                   a_fit;
	logic                   a_more;
	logic                   r_more_head;
	logic                   r_more;
	logic                   split;
	logic                   prev_join;
	logic                   blk_join;
	logic                   rel_bad;

	// Blocks needed for a byte count: rounded up to whole blocks, plus the header.
	function automatic logic [NEED_W-1:0] need_of(input logic [15:0] bytes);
		logic [16:0] padded;
		padded = {1'b0, bytes} + 17'(ffba_pkg::BLOCK_BYTES - 1);
		return NEED_W'(padded >> ffba_pkg::BLK_SHIFT) + 1'b1;
	endfunction

	ffba_store u_store (
		.clk     (clk),
		.req     (mreq),
		.pool    (pool_q),
		.rd_data (rd_data)
	);

	// Handshakes. A config transfer never lands on the same edge as a command.
	assign busy      = (state_q != S_IDLE);
	assign take      = start && !busy;
	assign cfg_ready = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		if (cfg_data < POOL_W'(2)) begin
			cfg_sat = POOL_W'(2);
		end else if (cfg_data > POOL_W'(ffba_pkg::POOL_DEPTH)) begin
			cfg_sat = POOL_W'(ffba_pkg::POOL_DEPTH);
		end else begin
			cfg_sat = cfg_data;
		end
	end

	assign pool_last = pool_q - POOL_W'(1);
	assign steps_inc = steps_q + POOL_W'(1);
	assign need_len  = LEN_W'(need_q);
	assign rest      = cur_q + IDX_W'(need_q);

	// Acquire walk: does the run just read fit, and may the walk go on past it.
	assign a_fit  = rd_data.len >= need_len;
	assign a_more = (rd_data.link != '0) && (steps_inc < pool_q);

	// Release walk: keep going while the next run lies below the released index.
	assign r_more_head = (rd_data.link != '0) && (rd_data.link < blk_q);
	assign r_more      = r_more_head && (steps_inc < pool_q);

	assign split     = ea_q.len > need_len;
	assign prev_join = (LEN_W'(prev_q) + ea_q.len) == LEN_W'(blk_q);
	assign blk_join  = (LEN_W'(blk_q) + eb_q.len) == LEN_W'(cur_q);

	assign rel_bad = (request.release_index == '0) ||
	                 (POOL_W'(request.release_index) >= pool_q);

	// Rebuilt pool: the head points at one run that covers everything else.
	always_comb begin
		clr_data = '0;
		if (clr_q == ADDR_W'(0)) begin
			clr_data.link = IDX_W'(1);
		end else if (clr_q == ADDR_W'(1)) begin
			clr_data.len = LEN_W'(pool_q) - LEN_W'(1);
		end
	end

	// Memory accesses issued by each state.
	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_CLEAR: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = IDX_W'(clr_q);
				mreq.wr_data = clr_data;
			end
			S_IDLE: begin
				mreq.rd_en   = take;
				mreq.rd_addr = '0;
			end
			S_AHEAD: begin
				mreq.rd_en   = (rd_data.link != '0);
				mreq.rd_addr = rd_data.link;
			end
			S_ACUR: begin
				mreq.rd_en   = !a_fit && a_more;
				mreq.rd_addr = rd_data.link;
			end
			S_AFOUND: begin
				// Split: the tail of the run becomes a free run of its own.
				mreq.wr_en        = split;
				mreq.wr_addr      = rest;
				mreq.wr_data.len  = ea_q.len - need_len;
				mreq.wr_data.link = ea_q.link;
			end
			S_APRD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = prev_q;
			end
			S_APWR: begin
				mreq.wr_en        = 1'b1;
				mreq.wr_addr      = prev_q;
				mreq.wr_data.len  = rd_data.len;
				mreq.wr_data.link = link_q;
			end
			S_ACRD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = cur_q;
			end
			S_ACWR: begin
				mreq.wr_en        = 1'b1;
				mreq.wr_addr      = cur_q;
				mreq.wr_data.len  = need_len;
				mreq.wr_data.link = rd_data.link;
			end
			S_RHEAD: begin
				mreq.rd_en   = r_more_head;
				mreq.rd_addr = rd_data.link;
			end
			S_RWALK: begin
				mreq.rd_en   = r_more;
				mreq.rd_addr = rd_data.link;
			end
			S_RBLK: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = blk_q;
			end
			S_RBLKD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = cur_q;
			end
			S_RNXTD: begin
				// Merge the released run with the run that follows it, or link it to that run.
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = blk_q;
				if (blk_join) begin
					mreq.wr_data.len  = eb_q.len + rd_data.len;
					mreq.wr_data.link = rd_data.link;
				end else begin
					mreq.wr_data.len  = eb_q.len;
					mreq.wr_data.link = cur_q;
				end
			end
			S_RPREV: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = prev_q;
			end
			S_RPREVD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = blk_q;
			end
			S_RFIX: begin
				// Merge into the preceding run, or link the preceding run to it.
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = prev_q;
				if (prev_join) begin
					mreq.wr_data.len  = ea_q.len + rd_data.len;
					mreq.wr_data.link = (cur_q == '0) ? ea_q.link : rd_data.link;
				end else begin
					mreq.wr_data.len  = ea_q.len;
					mreq.wr_data.link = blk_q;
				end
			end
			S_RLINK: begin
				// New last run of the list.
				mreq.wr_en        = 1'b1;
				mreq.wr_addr      = blk_q;
				mreq.wr_data.len  = eb_q.len;
				mreq.wr_data.link = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// Sequencer state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			pool_q   <= POOL_W'(ffba_pkg::POOL_DEPTH);
			clr_q    <= '0;
			need_q   <= '0;
			blk_q    <= '0;
			prev_q   <= '0;
			cur_q    <= '0;
			link_q   <= '0;
			steps_q  <= '0;
			ea_q     <= '0;
			eb_q     <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_fire) begin
				pool_q  <= cfg_sat;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				unique case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + ADDR_W'(1);
						if (clr_q == ADDR_W'(pool_last)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (take) begin
							need_q  <= need_of(request.request_bytes);
							blk_q   <= IDX_W'(request.release_index);
							prev_q  <= '0;
							steps_q <= '0;
							if (request.command == ffba_pkg::CMD_ACQUIRE) begin
								state_q <= S_AHEAD;
							end else if (rel_bad) begin
								done_q   <= 1'b1;
								result_q <= '{status: ffba_pkg::STATUS_RANGE, block_index: '0};
							end else begin
								state_q <= S_RHEAD;
							end
						end
					end
					S_AHEAD: begin
						cur_q <= rd_data.link;
						if (rd_data.link == '0) begin
							done_q   <= 1'b1;
							result_q <= '{status: ffba_pkg::STATUS_NO_MEMORY, block_index: '0};
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_ACUR;
						end
					end
					S_ACUR: begin
						if (a_fit) begin
							ea_q    <= rd_data;
							state_q <= S_AFOUND;
						end else begin
							prev_q  <= cur_q;
							cur_q   <= rd_data.link;
							steps_q <= steps_inc;
							if (!a_more) begin
								done_q   <= 1'b1;
								result_q <= '{status: ffba_pkg::STATUS_NO_MEMORY, block_index: '0};
								state_q  <= S_IDLE;
							end
						end
					end
					S_AFOUND: begin
						link_q  <= split ? rest : ea_q.link;
						state_q <= S_APRD;
					end
					S_APRD: begin
						state_q <= S_APWR;
					end
					S_APWR: begin
						state_q <= S_ACRD;
					end
					S_ACRD: begin
						state_q <= S_ACWR;
					end
					S_ACWR: begin
						done_q   <= 1'b1;
						result_q <= '{status: ffba_pkg::STATUS_OK, block_index: cur_q[ADDR_W-1:0]};
						state_q  <= S_IDLE;
					end
					S_RHEAD: begin
						cur_q <= rd_data.link;
						if (r_more_head) begin
							state_q <= S_RWALK;
						end else if (rd_data.link == '0) begin
							state_q <= S_RPREV;
						end else begin
							state_q <= S_RBLK;
						end
					end
					S_RWALK: begin
						prev_q  <= cur_q;
						cur_q   <= rd_data.link;
						steps_q <= steps_inc;
						if (!r_more) begin
							state_q <= (rd_data.link == '0) ? S_RPREV : S_RBLK;
						end
					end
					S_RBLK: begin
						state_q <= S_RBLKD;
					end
					S_RBLKD: begin
						eb_q    <= rd_data;
						state_q <= S_RNXTD;
					end
					S_RNXTD: begin
						state_q <= S_RPREV;
					end
					S_RPREV: begin
						state_q <= S_RPREVD;
					end
					S_RPREVD: begin
						ea_q    <= rd_data;
						state_q <= S_RFIX;
					end
					S_RFIX: begin
						eb_q <= rd_data;
						if ((cur_q == '0) && !prev_join) begin
							state_q <= S_RLINK;
						end else begin
							done_q   <= 1'b1;
							result_q <= '{status: ffba_pkg::STATUS_OK, block_index: '0};
							state_q  <= S_IDLE;
						end
					end
					S_RLINK: begin
						done_q   <= 1'b1;
						result_q <= '{status: ffba_pkg::STATUS_OK, block_index: '0};
						state_q  <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/ffba_store.sv =====
`timescale 1ns / 1ps
// Header store of the first-fit block allocator: one write port, one read port,
// registered read data; entries at or past the pool size read as zero and ignore writes.
// Depends on ffba_pkg.
module ffba_store (
	input  logic                         clk,
	input  ffba_pkg::store_req_t         req,
	input  logic [ffba_pkg::POOL_W-1:0]  pool,
	output ffba_pkg::entry_t             rd_data
);

	ffba_pkg::entry_t mem [ffba_pkg::POOL_DEPTH];
	ffba_pkg::entry_t rd_word_q;
	logic             rd_hit_q;
	logic [ffba_pkg::IDX_W-1:0] pool_ext;
	logic wr_hit;
	logic rd_hit;

	assign pool_ext = {{(ffba_pkg::IDX_W - ffba_pkg::POOL_W){1'b0}}, pool};
	assign wr_hit   = req.wr_addr < pool_ext;
	assign rd_hit   = req.rd_addr < pool_ext;

	always_ff @(posedge clk) begin
		if (req.wr_en && wr_hit) begin
			mem[req.wr_addr[ffba_pkg::ADDR_W-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_addr[ffba_pkg::ADDR_W-1:0]];
			rd_hit_q  <= rd_hit;
		end
	end

	assign rd_data = rd_hit_q ? rd_word_q : '0;

endmodule
